// ===== sv/omd_pkg.sv =====
// ----------------------------------------------------------------------------
// omd_pkg
// shared types, constants and row functions of the obstacle map dilation block
// ----------------------------------------------------------------------------
package omd_pkg;

    localparam int RADIUS     = 2;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 1024;

    localparam int SPAN    = 2 * RADIUS;
    localparam int NUM_RES = RADIUS + 1;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CFG_W   = 7;
    localparam int CNT_W   = $clog2(NUM_RES + 1);

    // result queue
    localparam int QDEPTH = NUM_RES + 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // state memory: one live entry holds the whole row window
    localparam int STATE_DEPTH = 2;
    localparam int STATE_AW    = $clog2(STATE_DEPTH);
    localparam logic [STATE_AW-1:0] STATE_ADDR = '0;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] row_blocked;
        logic                 last_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row_index;
        logic [MAX_WIDTH-1:0] walkable_row;
        logic                 map_done;
    } out_item_t;

    typedef struct packed {
        logic [SPAN-1:0][MAX_WIDTH-1:0] hist;
        logic [ROW_W-1:0]               rows_seen;
    } state_t;

    localparam int STATE_W = $bits(state_t);

    typedef struct packed {
        logic [CNT_W-1:0]              count;
        out_item_t [NUM_RES-1:0]       items;
    } bundle_t;

    // cells in use; widths above the row size act as the full row
    function automatic logic [MAX_WIDTH-1:0] width_mask(input logic [CFG_W-1:0] w);
        logic [MAX_WIDTH-1:0] m;
        m = '0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            m[c] = (CFG_W'(c) < w);
        end
        return m;
    endfunction

    // horizontal part of the window, then invert to walkable
    function automatic logic [MAX_WIDTH-1:0] walkable(input logic [MAX_WIDTH-1:0] r,
                                                      input logic [MAX_WIDTH-1:0] m);
        logic [MAX_WIDTH-1:0] d;
        d = r;
        for (int s = 1; s <= RADIUS; s++) begin
            d = d | (r << s) | (r >> s);
        end
        return ~d & m;
    endfunction

endpackage

// ===== sv/obstacle_map_dilation.sv =====
// ----------------------------------------------------------------------------
// obstacle_map_dilation
// inflates grid map obstacles with a 5x5 square binary dilation, row by row
// ----------------------------------------------------------------------------
// One map row enters per transfer as a 64-bit vector of blocked cells; after
// row i the block sends the walkable vector of row i-2, and the row flagged
// last also flushes the two pending rows (the final one carries map_done),
// after which a new map starts at row 0. The window of the last four rows and
// the row counter live in one word of a synchronous ram that is read every
// cycle and rewritten on every row; a forwarding register covers the word
// just written. Rows are taken one per cycle as long as results drain: the
// results that a row releases pass through the input register and the
// result queue registers before they reach m_valid. A last row pushes up to
// three results into a four-entry result queue, and new rows wait until that
// queue is down to one entry, so a last row can hold the input while it
// drains; this queue with its single output port sets the rate. No clearing
// pass is needed after reset. map_width may only be written while idle.
// ----------------------------------------------------------------------------
module obstacle_map_dilation (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: map width
    input  logic                          cfg_wr_en,
    input  logic [omd_pkg::CFG_W-1:0]     cfg_wr_data,
    // row input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  omd_pkg::in_item_t             s_data,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output omd_pkg::out_item_t            m_data
);

    // cells in use per row, full row after reset
    logic [omd_pkg::CFG_W-1:0]     map_width_reg;
    logic [omd_pkg::MAX_WIDTH-1:0] mask;

    // group of results from one row and the queue's go-ahead
    omd_pkg::bundle_t              bundle;
    logic                          room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg <= omd_pkg::CFG_W'(omd_pkg::MAX_WIDTH);
        end else if (cfg_wr_en) begin
            map_width_reg <= cfg_wr_data;
        end
    end

    // bits at or above the width are dropped on entry and zeroed on output
    assign mask = omd_pkg::width_mask(map_width_reg);

    // window update in ram, result computation and packing
    omd_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .mask    (mask),
        .room    (room),
        .bundle  (bundle)
    );

    // result queue, one result per output transfer
    omd_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .bundle  (bundle),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/omd_ram.sv =====
// ----------------------------------------------------------------------------
// omd_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module omd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/omd_window.sv =====
// ----------------------------------------------------------------------------
// omd_window
// row window held in ram: read, update with the new row, write back
// ----------------------------------------------------------------------------
module omd_window (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  omd_pkg::in_item_t               s_data,
    input  logic [omd_pkg::MAX_WIDTH-1:0]   mask,
    input  logic                            room,
    output omd_pkg::bundle_t                bundle
);

    logic                             s1_valid_reg;
    logic [omd_pkg::MAX_WIDTH-1:0]    s1_row_reg;
    logic                             s1_last_reg;
    logic                             fire;

    logic                             init_reg;
    logic                             fwd_sel_reg;
    omd_pkg::state_t                  fwd_reg;
    logic [omd_pkg::STATE_W-1:0]      ram_rdata;
    omd_pkg::state_t                  cur_state;
    omd_pkg::state_t                  state_next;

    logic [omd_pkg::MAX_WIDTH-1:0]    win [omd_pkg::SPAN+1];
    logic [omd_pkg::MAX_WIDTH-1:0]    acc [omd_pkg::NUM_RES];
    omd_pkg::out_item_t               raw [omd_pkg::NUM_RES];
    logic [omd_pkg::NUM_RES-1:0]      raw_valid;
    logic [omd_pkg::CNT_W-1:0]        cnt;
    logic [omd_pkg::CNT_W-1:0]        first;

    assign fire    = s1_valid_reg && room;
    assign s_ready = !s1_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            init_reg     <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (fire) begin
                init_reg <= 1'b1;
            end
            fwd_sel_reg <= fire;
        end
        if (s_valid && s_ready) begin
            s1_row_reg  <= s_data.row_blocked;
            s1_last_reg <= s_data.last_row;
        end
        if (fire) begin
            fwd_reg <= state_next;
        end
    end

    omd_ram #(
        .WIDTH (omd_pkg::STATE_W),
        .DEPTH (omd_pkg::STATE_DEPTH)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (fire),
        .wr_addr (omd_pkg::STATE_ADDR),
        .wr_data (state_next),
        .rd_en   (1'b1),
        .rd_addr (omd_pkg::STATE_ADDR),
        .rd_data (ram_rdata)
    );

    // the read issued alongside a write returns the old word, so forward it
    always_comb begin
        if (!init_reg) begin
            cur_state = '0;
        end else if (fwd_sel_reg) begin
            cur_state = fwd_reg;
        end else begin
            cur_state = omd_pkg::state_t'(ram_rdata);
        end
    end

    always_comb begin
        win[0] = s1_row_reg & mask;
        for (int k = 0; k < omd_pkg::SPAN; k++) begin
            win[k+1] = cur_state.hist[k] & mask;
        end

        for (int k = 0; k < omd_pkg::NUM_RES; k++) begin
            acc[k] = '0;
            for (int j = 0; j <= omd_pkg::SPAN - k; j++) begin
                acc[k] = acc[k] | win[j];
            end
            raw[k].row_index    = cur_state.rows_seen + omd_pkg::ROW_W'(k)
                                  - omd_pkg::ROW_W'(omd_pkg::RADIUS);
            raw[k].walkable_row = omd_pkg::walkable(acc[k], mask);
            raw[k].map_done     = (k == omd_pkg::RADIUS);
            if (k == 0) begin
                raw_valid[k] = ((omd_pkg::ROW_W+1)'(cur_state.rows_seen)
                                >= (omd_pkg::ROW_W+1)'(omd_pkg::RADIUS));
            end else begin
                raw_valid[k] = s1_last_reg
                               && (((omd_pkg::ROW_W+1)'(cur_state.rows_seen)
                                    + (omd_pkg::ROW_W+1)'(k))
                                   >= (omd_pkg::ROW_W+1)'(omd_pkg::RADIUS));
            end
        end

        // valid items form a suffix on the last row, so pack from the first one
        cnt   = omd_pkg::CNT_W'($countones(raw_valid));
        first = omd_pkg::CNT_W'(omd_pkg::NUM_RES) - cnt;
        bundle.count = fire ? cnt : '0;
        for (int j = 0; j < omd_pkg::NUM_RES; j++) begin
            bundle.items[j] = '0;
            if (!s1_last_reg) begin
                if (j == 0) begin
                    bundle.items[j] = raw[0];
                end
            end else begin
                for (int k = 0; k < omd_pkg::NUM_RES; k++) begin
                    if (omd_pkg::CNT_W'(k) == first + omd_pkg::CNT_W'(j)) begin
                        bundle.items[j] = raw[k];
                    end
                end
            end
        end

        if (s1_last_reg) begin
            state_next = '0;
        end else begin
            state_next.hist[0] = win[0];
            for (int k = 1; k < omd_pkg::SPAN; k++) begin
                state_next.hist[k] = cur_state.hist[k-1];
            end
            if (cur_state.rows_seen < omd_pkg::ROW_W'(omd_pkg::MAX_HEIGHT - 1)) begin
                state_next.rows_seen = cur_state.rows_seen + 1'b1;
            end else begin
                state_next.rows_seen = cur_state.rows_seen;
            end
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && s1_last_reg |=> cur_state.rows_seen == '0)
        else $error("window not cleared after last row");

    a_fwd_row: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !s1_last_reg |=> cur_state.hist[0] == $past(s1_row_reg & mask))
        else $error("new row not seen by the following item");

endmodule

// ===== sv/omd_emit.sv =====
// ----------------------------------------------------------------------------
// omd_emit
// result queue: takes a packed group of results, sends one per transfer
// ----------------------------------------------------------------------------
module omd_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  omd_pkg::bundle_t     bundle,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output omd_pkg::out_item_t   m_data
);

    omd_pkg::out_item_t            slot_reg  [omd_pkg::QDEPTH];
    omd_pkg::out_item_t            slot_next [omd_pkg::QDEPTH];
    logic [omd_pkg::QCNT_W-1:0]    count_reg;
    logic [omd_pkg::QCNT_W-1:0]    count_next;
    logic [omd_pkg::QCNT_W-1:0]    cnt_after;
    logic [omd_pkg::QCNT_W-1:0]    push_cnt;
    logic                          pop;

    assign room     = (count_reg <= omd_pkg::QCNT_W'(1));
    assign m_valid  = (count_reg != '0);
    assign m_data   = slot_reg[0];
    assign pop      = m_valid && m_ready;
    assign push_cnt = omd_pkg::QCNT_W'(bundle.count);

    always_comb begin
        cnt_after  = count_reg - omd_pkg::QCNT_W'(pop);
        count_next = cnt_after + push_cnt;
        for (int p = 0; p < omd_pkg::QDEPTH; p++) begin
            slot_next[p] = slot_reg[p];
            if (omd_pkg::QCNT_W'(p) < cnt_after) begin
                if (pop) begin
                    slot_next[p] = slot_reg[(p + 1 < omd_pkg::QDEPTH) ? p + 1 : p];
                end
            end else begin
                for (int j = 0; j < omd_pkg::NUM_RES; j++) begin
                    if (omd_pkg::QCNT_W'(j) < push_cnt
                        && omd_pkg::QCNT_W'(p) == cnt_after + omd_pkg::QCNT_W'(j)) begin
                        slot_next[p] = bundle.items[j];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        for (int p = 0; p < omd_pkg::QDEPTH; p++) begin
            slot_reg[p] <= slot_next[p];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= omd_pkg::QCNT_W'(omd_pkg::QDEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != '0 |-> room)
        else $error("results pushed without room");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push_cnt == '0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count lost a transfer");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 5x5 obstacle dilation of grid map rows
// ----------------------------------------------------------------------------
// Rows are queued by the stimulus process and sent by a clocked driver with
// random gaps. A clocked monitor keeps its own row window and row counter,
// works out the walkable rows due for every accepted row and checks each
// result transfer against the oldest one still pending. The map width is
// changed only between phases, once the block has gone quiet. The run covers
// short directed maps, random maps over a range of widths and a pause in the
// middle of a map.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [omd_pkg::MAX_WIDTH-1:0] row_t;

    localparam int REACH      = omd_pkg::RADIUS;  // window radius in rows and columns
    localparam int DEPTH      = 2 * REACH;        // rows kept behind the newest one
    localparam int LAST_INDEX = omd_pkg::MAX_HEIGHT - 1;
    localparam int SETTLE     = 8;                // quiet cycles before a width change
    localparam int IDLE_LIMIT = 3000;             // cycles with no transfer at all
    localparam int PHASE_ROWS = 40;               // least number of random rows per width setting

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // block inputs, all known from time zero
    logic                          cfg_wr_en   = 1'b0;
    logic [omd_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    omd_pkg::in_item_t             s_data      = '0;
    logic                          m_ready     = 1'b0;

    // block outputs
    logic                          s_ready;
    logic                          m_valid;
    omd_pkg::out_item_t            m_data;

    obstacle_map_dilation dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // rows waiting to be sent, and walkable rows waiting to come back
    omd_pkg::in_item_t  row_feed[$];
    omd_pkg::out_item_t walk_expect[$];

    // bookkeeping
    int   err_count      = 0;
    int   rows_queued    = 0;
    int   rows_in        = 0;
    int   results_seen   = 0;
    int   maps_sent      = 0;
    int   width_settings = 0;
    logic s_taken        = 1'b0;  // input transfer at the last rising edge

    // predictor copy of the block state
    row_t                          seen_rows[DEPTH];
    logic [omd_pkg::ROW_W-1:0]     next_index;
    logic [omd_pkg::CFG_W-1:0]     cur_width;

    // ------------------------------------------------------------------------
    // predictor helpers
    // ------------------------------------------------------------------------

    // cells in use; widths past the row size act as the full row, zero as none
    function automatic row_t cells_in_use(logic [omd_pkg::CFG_W-1:0] w);
        if (w >= omd_pkg::MAX_WIDTH)
            return '1;
        return (row_t'(1) << w) - row_t'(1);
    endfunction

    // horizontal reach of the window
    function automatic row_t spread_cols(row_t r);
        row_t d;
        d = r;
        for (int s = 1; s <= REACH; s++) begin
            d = d | (r << s) | (r >> s);
        end
        return d;
    endfunction

    task automatic clear_window();
        for (int k = 0; k < DEPTH; k++) begin
            seen_rows[k] = '0;
        end
        next_index = '0;
    endtask

    // one accepted row in, the walkable rows it releases appended to walk_expect
    task automatic predict_walkable(omd_pkg::in_item_t it);
        row_t               m;
        row_t               acc;
        row_t               win[DEPTH+1];
        int                 i;
        omd_pkg::out_item_t res;
        m = cells_in_use(cur_width);
        i = int'(next_index);
        // win[k] is row i-k, all masked to the current width
        win[0] = it.row_blocked & m;
        for (int k = 0; k < DEPTH; k++) begin
            win[k+1] = seen_rows[k] & m;
        end
        // centre row i-REACH sees the full vertical window
        if (i >= REACH) begin
            acc = '0;
            for (int k = 0; k <= DEPTH; k++) begin
                acc = acc | win[k];
            end
            res.row_index    = omd_pkg::ROW_W'(i - REACH);
            res.walkable_row = ~spread_cols(acc) & m;
            res.map_done     = 1'b0;
            walk_expect      = {walk_expect, res};
        end
        if (it.last_row) begin
            // flush the pending rows, window clipped at the bottom border
            for (int r = 1; r <= REACH; r++) begin
                if (i + r >= REACH) begin
                    acc = '0;
                    for (int k = 0; k <= DEPTH - r; k++) begin
                        acc = acc | win[k];
                    end
                    res.row_index    = omd_pkg::ROW_W'(i + r - REACH);
                    res.walkable_row = ~spread_cols(acc) & m;
                    res.map_done     = (r == REACH);
                    walk_expect      = {walk_expect, res};
                end
            end
            // next row starts a new map
            clear_window();
        end else begin
            for (int k = DEPTH - 1; k > 0; k--) begin
                seen_rows[k] = seen_rows[k-1];
            end
            seen_rows[0] = win[0];
            // row index saturates
            if (next_index < omd_pkg::ROW_W'(LAST_INDEX))
                next_index = next_index + 1'b1;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // monitor: width register, input transfers into the predictor, result check
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        omd_pkg::out_item_t want;
        if (!aresetn) begin
            cur_width = omd_pkg::CFG_W'(omd_pkg::MAX_WIDTH);
            clear_window();
            s_taken <= 1'b0;
        end else begin
            if (cfg_wr_en)
                cur_width = cfg_wr_data;
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                rows_in++;
                predict_walkable(s_data);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (walk_expect.size() == 0) begin
                    report_mismatch("result with nothing pending, row_index",
                                    64'(m_data.row_index), 64'd0);
                end else begin
                    want = walk_expect.pop_front();
                    if (m_data.row_index !== want.row_index)
                        report_mismatch("row_index", 64'(m_data.row_index),
                                        64'(want.row_index));
                    if (m_data.walkable_row !== want.walkable_row)
                        report_mismatch($sformatf("walkable_row of row %0d", want.row_index),
                                        m_data.walkable_row, want.walkable_row);
                    if (m_data.map_done !== want.map_done)
                        report_mismatch($sformatf("map_done of row %0d", want.row_index),
                                        64'(m_data.map_done), 64'(want.map_done));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles, %0d results pending",
                         $time, idle_cycles, walk_expect.size());
                $display("obstacle_map_dilation: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // idle gaps: mostly none or short, now and then long; calm stretches have none
    // ------------------------------------------------------------------------
    function automatic int draw_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // driver: rows from row_feed, changed at the falling edge
    // ------------------------------------------------------------------------
    int send_gap  = 0;
    bit send_calm = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            // the row on the bus, if any, went out at the last rising edge
            if (s_valid) begin
                send_gap = draw_gap(send_calm);
                if ($urandom_range(0, 39) == 0)
                    send_calm = ~send_calm;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (row_feed.size() > 0) begin
                s_data  <= row_feed.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls on m_ready
    // ------------------------------------------------------------------------
    int stall_left = 0;
    bit recv_calm  = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = draw_gap(recv_calm);
            if ($urandom_range(0, 63) == 0)
                recv_calm = ~recv_calm;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_row(row_t r, bit last);
        omd_pkg::in_item_t it;
        it.row_blocked = r;
        it.last_row    = last;
        row_feed       = {row_feed, it};
        rows_queued++;
        if (last)
            maps_sent++;
    endtask

    // mostly sparse rows so that walkable cells survive the dilation
    function automatic row_t make_row();
        row_t r;
        int   kind;
        int   n;
        r    = '0;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            r = '0;
        end else if (kind < 13) begin
            n = $urandom_range(1, 3);
            repeat (n) r[$urandom_range(0, omd_pkg::MAX_WIDTH - 1)] = 1'b1;
        end else if (kind < 15) begin
            r = {$urandom, $urandom};
        end else if (kind < 16) begin
            r = '1;
        end else if (kind < 18) begin
            r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        end else begin
            // cells next to either border
            if ($urandom_range(0, 1))
                r[omd_pkg::MAX_WIDTH - 1 - $urandom_range(0, 2)] = 1'b1;
            else
                r[$urandom_range(0, 2)] = 1'b1;
        end
        return r;
    endfunction

    // mostly short maps, some of a few dozen rows
    function automatic int map_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    // every queued row accepted and every pending result back
    task automatic wait_drained();
        while (rows_in != rows_queued || walk_expect.size() != 0)
            @(negedge aclk);
    endtask

    // a row that releases no result may still be in flight, so let it settle
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_width(logic [omd_pkg::CFG_W-1:0] w);
        quiesce();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        width_settings++;
    endtask

    task automatic random_phase(logic [omd_pkg::CFG_W-1:0] w, bit pause_inside);
        int made;
        int len;
        set_width(w);
        made = 0;
        if (pause_inside) begin
            // sender holds off mid map until every pending result is back
            for (int r = 0; r < 7; r++) push_row(make_row(), 1'b0);
            wait_drained();
            for (int r = 0; r < 5; r++) push_row(make_row(), r == 4);
            made = 12;
        end
        while (made < PHASE_ROWS) begin
            len = map_len();
            for (int r = 0; r < len; r++) push_row(make_row(), r == len - 1);
            made += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed maps at full width
        set_width(omd_pkg::CFG_W'(omd_pkg::MAX_WIDTH));
        push_row('1, 1'b1);                            // one-row map, fully blocked
        push_row('0, 1'b1);                            // one-row map, empty
        push_row(64'h1, 1'b0);                         // two rows, border cells
        push_row(64'h8000_0000_0000_0000, 1'b1);
        push_row('0, 1'b0);                            // three rows, middle cell
        push_row(64'h0000_0001_0000_0000, 1'b0);
        push_row('0, 1'b1);
        push_row('0, 1'b0);                            // five rows, square footprint
        push_row('0, 1'b0);
        push_row(64'h0000_0001_0000_0001, 1'b0);
        push_row('0, 1'b0);
        push_row('0, 1'b1);
        push_row('1, 1'b0);                            // top border blocked, reach check
        push_row('0, 1'b0);
        push_row('0, 1'b0);
        push_row('0, 1'b0);
        push_row('0, 1'b0);
        push_row(64'h5555_5555_5555_5555, 1'b1);

        // width extremes, including out of range values
        set_width(omd_pkg::CFG_W'(1));
        push_row('0, 1'b0);
        push_row('1, 1'b1);
        set_width(omd_pkg::CFG_W'(0));
        push_row('0, 1'b1);
        set_width(omd_pkg::CFG_W'(127));
        push_row(64'h8000_0000_0000_0001, 1'b0);
        push_row('0, 1'b1);

        // random maps over several widths
        random_phase(omd_pkg::CFG_W'(1), 1'b0);
        random_phase(omd_pkg::CFG_W'(0), 1'b0);
        random_phase(omd_pkg::CFG_W'(127), 1'b1);
        random_phase(omd_pkg::CFG_W'(65), 1'b0);
        random_phase(omd_pkg::CFG_W'(63), 1'b0);
        random_phase(omd_pkg::CFG_W'(2), 1'b0);
        random_phase(omd_pkg::CFG_W'(omd_pkg::MAX_WIDTH), 1'b0);
        random_phase(omd_pkg::CFG_W'($urandom_range(3, omd_pkg::MAX_WIDTH - 2)), 1'b0);
        random_phase(omd_pkg::CFG_W'($urandom_range(0, 127)), 1'b0);

        quiesce();

        $display("sent %0d rows in %0d maps over %0d width settings",
                 rows_in, maps_sent, width_settings);
        $display("checked %0d walkable rows, %0d mismatches", results_seen, err_count);
        if (err_count == 0)
            $display("obstacle_map_dilation: match");
        else
            $display("obstacle_map_dilation: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/omd_pkg.sv
sv/omd_ram.sv
sv/omd_window.sv
sv/omd_emit.sv
sv/obstacle_map_dilation.sv
dv/tb_top.sv
